// ===== hdl/fowa_pkg.sv =====
// Package for the frame owner allocator.
// Holds the transfer payload types, the token handed between cells and the mode codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fowa_pkg;

    localparam int FRAME_W     = 6;
    localparam int PID_W       = 16;
    localparam int MODE_W      = 3;
    localparam int FIU_W       = 7;
    localparam int DEF_NUM_FRAMES = 64;
    localparam int DEF_PID_BITS   = 16;

    localparam logic [FIU_W-1:0] FIU_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ASSIGN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FREE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

    localparam int REG_FIU = 0;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [PID_W-1:0]   pid;
        logic [FRAME_W-1:0] frame;
    } fowa_in_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_out;
        logic               success;
        logic [PID_W-1:0]   owner_pid;
        logic               owner_valid;
    } fowa_out_t;

    typedef struct packed {
        logic               valid;
        logic [MODE_W-1:0]  mode;
        logic [PID_W-1:0]   pid;
        logic [FRAME_W-1:0] frame;
        logic               found;
        logic [FRAME_W-1:0] grant;
        logic [PID_W-1:0]   owner_pid;
        logic               owner_valid;
    } fowa_tok_t;

endpackage

`default_nettype wire

// ===== hdl/frame_owner_allocator.sv =====
// Top level of the frame owner allocator: APB register block and the row of frame cells.
// Depends on fowa_pkg, fowa_regs and fowa_cell.
`timescale 1ns / 1ps
`default_nettype none

// Each request travels down a row of NUM_FRAMES cells, one cell per cycle while the row
// advances, and each cell applies it to its own frame; the token leaving the last cell is
// the output register. One transfer per cycle is sustained while m_ready stays high. A
// stalled output holds the whole row. After reset every frame is free, frames_in_use is 64,
// and frames_in_use sits at byte address 0; frames_in_use must be written only while no
// request is in flight, which the block itself does not enforce.
module frame_owner_allocator #(
    parameter int NUM_FRAMES = fowa_pkg::DEF_NUM_FRAMES,
    parameter int PID_BITS   = fowa_pkg::DEF_PID_BITS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire fowa_pkg::fowa_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output fowa_pkg::fowa_out_t      m_data,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);
    import fowa_pkg::*;

    localparam logic [PID_W-1:0] PID_MASK =
        (PID_BITS >= PID_W) ? {PID_W{1'b1}} : PID_W'((64'd1 << PID_BITS) - 64'd1);

    logic [FIU_W-1:0] frames_in_use;
    logic             adv;
    fowa_tok_t        tok [NUM_FRAMES+1];
    fowa_tok_t        last;

    fowa_regs u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .frames_in_use (frames_in_use)
    );

    assign last    = tok[NUM_FRAMES];
    assign adv     = !last.valid || m_ready;
    assign s_ready = adv;
    assign m_valid = last.valid;

    always_comb begin
        tok[0]             = '0;
        tok[0].valid       = s_valid;
        tok[0].mode        = s_data.mode;
        tok[0].pid         = s_data.pid & PID_MASK;
        tok[0].frame       = s_data.frame;
    end

    for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
        fowa_cell #(
            .CELL_IDX (i),
            .PID_BITS (PID_BITS)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .adv           (adv),
            .frames_in_use (frames_in_use),
            .tok_i         (tok[i]),
            .tok_o         (tok[i+1])
        );
    end

    always_comb begin
        m_data.success     = (last.mode == MODE_ALLOC) && last.found;
        m_data.owner_pid   = last.owner_pid;
        m_data.owner_valid = last.owner_valid;
        if (last.mode == MODE_ALLOC) begin
            m_data.frame_out = last.found ? last.grant : '0;
        end else begin
            m_data.frame_out = last.frame;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fowa_regs.sv =====
// APB register block of the frame owner allocator: the frames_in_use register.
// Depends on fowa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fowa_regs (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output logic      [fowa_pkg::FIU_W-1:0] frames_in_use
);
    import fowa_pkg::*;

    logic [FIU_W-1:0] fiu_reg;
    logic             sel_fiu;

    assign sel_fiu       = (int'(paddr[2]) == REG_FIU);
    assign pready        = 1'b1;
    assign frames_in_use = fiu_reg;
    assign prdata        = sel_fiu ? {{(32-FIU_W){1'b0}}, fiu_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fiu_reg <= FIU_RESET;
        end else if (psel && penable && pwrite && pready && sel_fiu) begin
            fiu_reg <= pwdata[FIU_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fowa_cell.sv =====
// One frame cell: used bit and owner of one physical frame, acting on the passing token.
// Depends on fowa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fowa_cell #(
    parameter int CELL_IDX = 0,
    parameter int PID_BITS = fowa_pkg::DEF_PID_BITS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       adv,
    input  wire logic [fowa_pkg::FIU_W-1:0] frames_in_use,
    input  wire fowa_pkg::fowa_tok_t        tok_i,
    output fowa_pkg::fowa_tok_t             tok_o
);
    import fowa_pkg::*;

    logic                used_reg, used_next;
    logic [PID_BITS-1:0] owner_reg, owner_next;
    fowa_tok_t           tok_reg, tok_next;
    logic                hit, in_lim;

    assign hit    = (CELL_IDX == int'(tok_i.frame));
    assign in_lim = (CELL_IDX < int'(frames_in_use));
    assign tok_o  = tok_reg;

    always_comb begin
        used_next  = used_reg;
        owner_next = owner_reg;
        tok_next   = tok_i;
        if (tok_i.valid) begin
            unique case (tok_i.mode)
                MODE_ALLOC: begin
                    if (!tok_i.found && !used_reg && in_lim) begin
                        used_next      = 1'b1;
                        owner_next     = PID_BITS'(tok_i.pid);
                        tok_next.found = 1'b1;
                        tok_next.grant = FRAME_W'(CELL_IDX);
                    end
                end
                MODE_ASSIGN: begin
                    if (hit && in_lim) begin
                        used_next  = 1'b1;
                        owner_next = PID_BITS'(tok_i.pid);
                    end
                end
                MODE_FREE: begin
                    if (hit && in_lim) begin
                        used_next = 1'b0;
                    end
                end
                MODE_RELEASE: begin
                    if (used_reg && owner_reg == PID_BITS'(tok_i.pid)) begin
                        used_next = 1'b0;
                    end
                end
                MODE_READ: begin
                    if (hit && in_lim && used_reg) begin
                        tok_next.owner_pid   = PID_W'(owner_reg);
                        tok_next.owner_valid = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else if (adv) begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            owner_reg <= owner_next;
        end
    end

endmodule

`default_nettype wire
